@@ sv/wrd_pkg.sv @@
package wrd_pkg;

    // Header layout and delta arithmetic.
    localparam int unsigned HDR_LEN     = 11;
    localparam int unsigned DELTA_SHIFT = 4;
    localparam logic [31:0] DELTA_BIAS  = 32'h0008_0000;

    // Byte positions that finish a field.
    localparam logic [3:0] PH_TYPE      = 4'd0;
    localparam logic [3:0] PH_COUNT_LO  = 4'd2;
    localparam logic [3:0] PH_X_LO      = 4'd6;
    localparam logic [3:0] PH_Y_LO      = 4'd10;
    localparam logic [3:0] PH_HDR_LAST  = 4'(HDR_LEN - 1);
    localparam logic [3:0] PH_DELTA_END = 4'd3;

    // One decoded point.
    typedef struct packed {
        logic [7:0]  way_type;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [15:0] point_index;
        logic        last_point;
    } t_point;

    // Status from the parser to the output stage.
    typedef struct packed {
        logic res_valid;
        logic in_deltas;
    } t_parse_status;

    // Add a scaled, biased 16-bit delta to a running coordinate.
    function automatic logic [31:0] apply_delta(input logic [31:0] acc,
                                                input logic [15:0] d16);
        logic [31:0] step;
        step = 32'(d16) << DELTA_SHIFT;
        return acc + step - DELTA_BIAS;
    endfunction

endpackage

@@ sv/way_record_delta_decoder.sv @@
// Way record delta decoder.
// Input channel: i_valid / o_stall carry one byte of the record stream per
// transaction, with i_start_req forcing that byte to be a new type byte.
// Output channel: o_valid / i_stall carry one decoded point per transaction:
// type, absolute x and y, index within the way and a last-point flag.
// A record is an 11-byte header (type, 16-bit count, 32-bit x, 32-bit y)
// followed by 4-byte delta groups; the header gives the first point and each
// group one more. A record with count zero gives no point.
// Throughput is one byte per cycle while o_stall is low. A completed point is
// registered (output or skid register); the parser update and the delta add
// form a single stage ahead of the output register.
// When the receiver stalls, the next point is caught in a skid register and
// o_stall rises only while that register is full; bytes that complete no
// point are still taken until then. When the receiver takes the held point
// the skid point moves up and o_stall drops in the following cycle.
// Reset clears the parser to expect a header and empties both output
// registers; no clearing pass is needed.
module way_record_delta_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_req,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_way_type,
    output logic [31:0] o_point_x,
    output logic [31:0] o_point_y,
    output logic [15:0] o_point_index,
    output logic        o_last_point
);

    wrd_pkg::t_parse_status status;
    wrd_pkg::t_point        res;

    logic            in_accept;
    logic            out_free;
    logic            new_point;
    logic            r_out_valid;
    logic            r_skid_valid;
    wrd_pkg::t_point r_out;
    wrd_pkg::t_point r_skid;

    assign in_accept = i_valid && !r_skid_valid;
    assign out_free  = !r_out_valid || !i_stall;
    assign new_point = in_accept && status.res_valid;

    wrd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_accept),
        .i_data_byte (i_data_byte),
        .i_start_req (i_start_req),
        .o_status    (status),
        .o_point     (res)
    );

    // Output register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out       <= res;
                r_out_valid <= new_point;
            end
        end else if (new_point) begin
            r_skid       <= res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_stall       = r_skid_valid;
    assign o_valid       = r_out_valid;
    assign o_way_type    = r_out.way_type;
    assign o_point_x     = r_out.point_x;
    assign o_point_y     = r_out.point_y;
    assign o_point_index = r_out.point_index;
    assign o_last_point  = r_out.last_point;

    // The skid register only fills behind a held output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // A point that is not the last leaves the parser in the delta groups.
    a_more_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (new_point && !res.last_point) |=> status.in_deltas)
        else $error("parser left delta groups before the last point");

    // The last point of a way returns the parser to header parsing.
    a_way_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (new_point && res.last_point) |=> !status.in_deltas)
        else $error("parser stayed in delta groups after the last point");

endmodule

@@ sv/wrd_parser.sv @@
module wrd_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_start_req,
    output wrd_pkg::t_parse_status o_status,
    output wrd_pkg::t_point        o_point
);

    logic [3:0]  r_phase,   n_phase;
    logic        r_in_deltas, n_in_deltas;
    logic [7:0]  r_type,    n_type;
    logic [15:0] r_count,   n_count;
    logic [15:0] r_counter, n_counter;
    logic [31:0] r_acc_x,   n_acc_x;
    logic [31:0] r_acc_y,   n_acc_y;
    logic [23:0] r_shift,   n_shift;

    logic [31:0] full;
    logic [3:0]  ph;
    logic        ind;
    logic [15:0] idx_next;
    logic        delta_last;
    logic        res_valid;
    logic [15:0] res_index;
    logic        res_last;

    assign full       = {r_shift, i_data_byte};
    assign idx_next   = 16'(r_counter + 16'd1);
    assign delta_last = (idx_next == r_count) || (r_counter >= r_count);

    // Next state and result for the byte being accepted.
    always_comb begin
        n_phase     = r_phase;
        n_in_deltas = r_in_deltas;
        n_type      = r_type;
        n_count     = r_count;
        n_counter   = r_counter;
        n_acc_x     = r_acc_x;
        n_acc_y     = r_acc_y;
        n_shift     = r_shift;
        res_valid   = 1'b0;
        res_index   = 16'd0;
        res_last    = 1'b0;

        // A start request drops any record in progress.
        ph  = i_start_req ? wrd_pkg::PH_TYPE : r_phase;
        ind = i_start_req ? 1'b0 : r_in_deltas;

        if (ind) begin
            if (ph > wrd_pkg::PH_DELTA_END) begin
                ph = wrd_pkg::PH_TYPE;
            end
            if (ph < wrd_pkg::PH_DELTA_END) begin
                n_shift = full[23:0];
                n_phase = 4'(ph + 4'd1);
            end else begin
                n_acc_x   = wrd_pkg::apply_delta(r_acc_x, full[31:16]);
                n_acc_y   = wrd_pkg::apply_delta(r_acc_y, full[15:0]);
                res_valid = 1'b1;
                res_index = r_counter;
                res_last  = delta_last;
                n_shift   = 24'd0;
                n_phase   = wrd_pkg::PH_TYPE;
                if (delta_last) begin
                    n_in_deltas = 1'b0;
                end else begin
                    n_counter = idx_next;
                end
            end
        end else begin
            if (ph > wrd_pkg::PH_HDR_LAST) begin
                ph = wrd_pkg::PH_TYPE;
            end
            n_in_deltas = 1'b0;
            case (ph)
                wrd_pkg::PH_TYPE: begin
                    n_type  = i_data_byte;
                    n_shift = 24'd0;
                    n_phase = 4'd1;
                end
                wrd_pkg::PH_COUNT_LO: begin
                    n_count = full[15:0];
                    n_shift = 24'd0;
                    n_phase = 4'(ph + 4'd1);
                end
                wrd_pkg::PH_X_LO: begin
                    n_acc_x = full;
                    n_shift = 24'd0;
                    n_phase = 4'(ph + 4'd1);
                end
                wrd_pkg::PH_Y_LO: begin
                    n_acc_y = full;
                    n_shift = 24'd0;
                    n_phase = wrd_pkg::PH_TYPE;
                    // An empty record ends here without a point.
                    if (r_count != 16'd0) begin
                        res_valid = 1'b1;
                        res_index = 16'd0;
                        res_last  = (r_count == 16'd1);
                    end
                    if (r_count > 16'd1) begin
                        n_in_deltas = 1'b1;
                        n_counter   = 16'd1;
                    end
                end
                default: begin
                    n_shift = full[23:0];
                    n_phase = 4'(ph + 4'd1);
                end
            endcase
        end
    end

    // Parser state advances only on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= wrd_pkg::PH_TYPE;
            r_in_deltas <= 1'b0;
            r_type      <= 8'd0;
            r_count     <= 16'd0;
            r_counter   <= 16'd0;
            r_acc_x     <= 32'd0;
            r_acc_y     <= 32'd0;
            r_shift     <= 24'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_in_deltas <= n_in_deltas;
            r_type      <= n_type;
            r_count     <= n_count;
            r_counter   <= n_counter;
            r_acc_x     <= n_acc_x;
            r_acc_y     <= n_acc_y;
            r_shift     <= n_shift;
        end
    end

    assign o_status.res_valid = res_valid;
    assign o_status.in_deltas = r_in_deltas;

    assign o_point.way_type    = n_type;
    assign o_point.point_x     = n_acc_x;
    assign o_point.point_y     = n_acc_y;
    assign o_point.point_index = res_index;
    assign o_point.last_point  = res_last;

endmodule
